// ----- rtl/otcv_pkg.sv -----
`timescale 1ns / 1ps
package otcv_pkg;

    localparam int COIN_LIMIT     = 15;
    localparam int COUNTS_PER_DAY = 25;
    localparam int USED_DEPTH     = 512;
    localparam int COIN_W  = (COIN_LIMIT > 1) ? $clog2(COIN_LIMIT) : 1;
    localparam int CNT_W   = (COUNTS_PER_DAY > 1) ? $clog2(COUNTS_PER_DAY) : 1;
    localparam int ADDR_W  = $clog2(USED_DEPTH);
    localparam int TOTAL_W = ADDR_W + 1;

    localparam logic [1:0] VERDICT_OK   = 2'd0;
    localparam logic [1:0] VERDICT_USED = 2'd1;
    localparam logic [1:0] VERDICT_FAKE = 2'd2;

    localparam logic [13:0] SERIAL_RESET = 14'd1234;

    typedef struct packed {
        logic [26:0] entered_code;
        logic [19:0] date_code;
    } req_t;

    typedef struct packed {
        logic [1:0] verdict;
        logic [3:0] coin_value;
    } rsp_t;

    // controller to datapath
    typedef struct packed {
        logic load;        // latch request, handle date change
        logic seed_start;  // start half code for current seed
        logic sel_b;       // 0 = seed a, 1 = seed b
        logic hold_high;   // keep finished half as the high half
        logic hold_cand;   // build candidate from high half and finished half
        logic cand_next;   // advance counter/coin
        logic scan_start;  // reset scan index
        logic scan_step;   // advance scan index
        logic append;      // write code to list
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic half_done;
        logic match;
        logic cand_last;
        logic scan_end;
        logic scan_hit;
    } sts_t;

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_SEEDA = 9'b000000010,
        ST_WAITA = 9'b000000100,
        ST_WAITB = 9'b000001000,
        ST_CMP   = 9'b000010000,
        ST_SCAN0 = 9'b000100000,
        ST_SCAN  = 9'b001000000,
        ST_DONE  = 9'b010000000,
        ST_OUT   = 9'b100000000
    } state_t;

endpackage

// ----- rtl/otcv_ram.sv -----
`timescale 1ns / 1ps
module otcv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ----- rtl/otcv_half.sv -----
`timescale 1ns / 1ps
// one schrage step then 1000 + t mod 9000; both divisions by reciprocal multiply
// plus one correcting subtract, done pulses once the H_FIN step has finished
module otcv_half (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [31:0] seed,
    output logic        done,
    output logic [13:0] half
);
    typedef enum logic [8:0] {
        H_IDLE = 9'b000000001,
        H_QEST = 9'b000000010,
        H_QSUB = 9'b000000100,
        H_QFIX = 9'b000001000,
        H_LEH  = 9'b000010000,
        H_WRAP = 9'b000100000,
        H_MEST = 9'b001000000,
        H_MSUB = 9'b010000000,
        H_FIN  = 9'b100000000
    } hstate_t;

    hstate_t     st_reg, st_next;
    logic [31:0] seed_reg, seed_next;
    logic [15:0] q_reg, q_next;
    logic [17:0] r_reg, r_next;
    logic [32:0] t_reg, t_next;
    logic [17:0] mq_reg, mq_next;
    logic [14:0] m_reg, m_next;
    logic [13:0] half_reg, half_next;
    logic        done_reg, done_next;

    logic [47:0] qprod;
    logic [31:0] qmul;
    logic [31:0] rdiff;
    logic [31:0] lprod_r, lprod_q;
    logic [32:0] ldiff;
    logic [48:0] mprod;
    logic [31:0] mmul;
    logic [31:0] mdiff;
    logic [14:0] m_fix;

    always_comb begin
        // quotient estimate, floor(2^32 / 127773) = 33614, low by at most one
        qprod = 48'(seed_reg) * 48'd33614;
        qmul = 32'(q_reg) * 32'd127773;
        rdiff = seed_reg - qmul;
        lprod_r = 32'(r_reg[16:0]) * 32'd16807;
        lprod_q = 32'(q_reg) * 32'd2836;
        ldiff = 33'(lprod_r) - 33'(lprod_q);
        // floor(2^31 / 9000) = 238609, low by at most one
        mprod = 49'(t_reg[30:0]) * 49'd238609;
        mmul = 32'(mq_reg) * 32'd9000;
        mdiff = 32'(t_reg[30:0]) - mmul;
        m_fix = (m_reg >= 15'd9000) ? 15'(m_reg - 15'd9000) : m_reg;
    end

    always_comb begin
        st_next = st_reg;
        seed_next = seed_reg;
        q_next = q_reg;
        r_next = r_reg;
        t_next = t_reg;
        mq_next = mq_reg;
        m_next = m_reg;
        half_next = half_reg;
        done_next = 1'b0;
        case (st_reg)
            H_IDLE: begin
                if (start) begin
                    seed_next = seed;
                    st_next = H_QEST;
                end
            end
            H_QEST: begin
                q_next = qprod[47:32];
                st_next = H_QSUB;
            end
            H_QSUB: begin
                r_next = rdiff[17:0];
                st_next = H_QFIX;
            end
            H_QFIX: begin
                if (r_reg >= 18'd127773) begin
                    r_next = 18'(r_reg - 18'd127773);
                    q_next = 16'(q_reg + 16'd1);
                end
                st_next = H_LEH;
            end
            H_LEH: begin
                t_next = ldiff;
                st_next = H_WRAP;
            end
            H_WRAP: begin
                if ($signed(t_reg) <= 33'sd0) begin
                    t_next = 33'(t_reg + 33'h07FFFFFFF);
                end
                st_next = H_MEST;
            end
            H_MEST: begin
                mq_next = mprod[48:31];
                st_next = H_MSUB;
            end
            H_MSUB: begin
                m_next = mdiff[14:0];
                st_next = H_FIN;
            end
            H_FIN: begin
                half_next = 14'(m_fix) + 14'd1000;
                done_next = 1'b1;
                st_next = H_IDLE;
            end
            default: st_next = H_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= H_IDLE;
            done_reg <= 1'b0;
        end else begin
            st_reg <= st_next;
            done_reg <= done_next;
        end
        seed_reg <= seed_next;
        q_reg <= q_next;
        r_reg <= r_next;
        t_reg <= t_next;
        mq_reg <= mq_next;
        m_reg <= m_next;
        half_reg <= half_next;
    end

    assign done = done_reg;
    assign half = half_reg;
endmodule

// ----- rtl/otcv_datapath.sv -----
`timescale 1ns / 1ps
module otcv_datapath (
    input  logic                aclk,
    input  logic                aresetn,
    input  otcv_pkg::req_t      req,
    input  logic [13:0]         serial,
    input  otcv_pkg::cmd_t      cmd,
    output otcv_pkg::sts_t      sts,
    output logic [3:0]          coin_out
);
    otcv_pkg::req_t req_reg;
    logic [19:0] date_reg;
    logic [otcv_pkg::TOTAL_W-1:0] total_reg;
    logic [otcv_pkg::COIN_W-1:0] coin_reg;
    logic [otcv_pkg::CNT_W-1:0] cnt_reg;
    logic [otcv_pkg::TOTAL_W-1:0] scan_reg;
    logic [13:0] high_reg;
    logic [26:0] cand_reg;

    logic [31:0] seed_a, seed_b, seed;
    logic        hdone;
    logic [13:0] half;
    logic [26:0] rdata;
    logic [26:0] hi_x;
    logic        list_full;
    logic        list_we;

    assign seed_a = {req_reg.date_code[19:0], 12'd0} | 32'({8'(cnt_reg)});
    assign seed_b = {2'd0, serial, 8'(cnt_reg), 8'(coin_reg)};
    assign seed = cmd.sel_b ? seed_b : seed_a;

    otcv_half u_half (
        .aclk(aclk), .aresetn(aresetn), .start(cmd.seed_start),
        .seed(seed), .done(hdone), .half(half)
    );

    // high * 10000 as shifts: 8192+1024+512+256+16
    assign hi_x = (27'(high_reg) << 13) + (27'(high_reg) << 10) + (27'(high_reg) << 9)
                + (27'(high_reg) << 8) + (27'(high_reg) << 4);

    // a full list still answers ok but keeps nothing
    assign list_full = (total_reg >= otcv_pkg::TOTAL_W'(otcv_pkg::USED_DEPTH));
    assign list_we = cmd.append && !list_full;

    otcv_ram #(.WIDTH(27), .DEPTH(otcv_pkg::USED_DEPTH)) u_ram (
        .aclk(aclk), .we(list_we),
        .waddr(total_reg[otcv_pkg::ADDR_W-1:0]), .wdata(req_reg.entered_code),
        .raddr(scan_reg[otcv_pkg::ADDR_W-1:0]), .rdata(rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            date_reg <= '0;
            total_reg <= '0;
        end else begin
            if (cmd.load && req.date_code != date_reg) begin
                date_reg <= req.date_code;
                total_reg <= '0;
            end
            if (list_we) begin
                total_reg <= total_reg + 1'b1;
            end
        end
        if (cmd.load) begin
            req_reg <= req;
            coin_reg <= otcv_pkg::COIN_W'(1);
            cnt_reg <= '0;
        end
        if (cmd.cand_next) begin
            if (cnt_reg == otcv_pkg::CNT_W'(otcv_pkg::COUNTS_PER_DAY - 1)) begin
                cnt_reg <= '0;
                coin_reg <= coin_reg + 1'b1;
            end else begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
        if (cmd.hold_high) high_reg <= half;
        if (cmd.hold_cand) cand_reg <= hi_x + 27'(half);
        if (cmd.scan_start) scan_reg <= '0;
        else if (cmd.scan_step) scan_reg <= scan_reg + 1'b1;
    end

    always_comb begin
        sts.half_done = hdone;
        sts.match = (cand_reg == req_reg.entered_code);
        sts.cand_last = (cnt_reg == otcv_pkg::CNT_W'(otcv_pkg::COUNTS_PER_DAY - 1))
                     && (coin_reg == otcv_pkg::COIN_W'(otcv_pkg::COIN_LIMIT - 1));
        sts.scan_end = (scan_reg >= total_reg);
        sts.scan_hit = (rdata == req_reg.entered_code);
    end

    assign coin_out = 4'(coin_reg);
endmodule

// ----- rtl/otcv_ctrl.sv -----
`timescale 1ns / 1ps
module otcv_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    output logic            m_valid,
    input  logic            m_ready,
    input  otcv_pkg::sts_t  sts,
    input  logic [3:0]      coin_dp,
    output otcv_pkg::cmd_t  cmd,
    output otcv_pkg::rsp_t  rsp
);
    otcv_pkg::state_t st_reg, st_next;
    otcv_pkg::rsp_t   rsp_reg, rsp_next;

    always_comb begin
        st_next = st_reg;
        rsp_next = rsp_reg;
        cmd = '0;
        cmd.sel_b = (st_reg == otcv_pkg::ST_WAITB);
        case (st_reg)
            otcv_pkg::ST_IDLE: begin
                if (s_valid) begin
                    cmd.load = 1'b1;
                    st_next = otcv_pkg::ST_SEEDA;
                end
            end
            otcv_pkg::ST_SEEDA: begin
                cmd.seed_start = 1'b1;
                st_next = otcv_pkg::ST_WAITA;
            end
            otcv_pkg::ST_WAITA: begin
                if (sts.half_done) begin
                    cmd.hold_high = 1'b1;
                    cmd.seed_start = 1'b1;
                    cmd.sel_b = 1'b1;
                    st_next = otcv_pkg::ST_WAITB;
                end
            end
            otcv_pkg::ST_WAITB: begin
                if (sts.half_done) begin
                    cmd.hold_cand = 1'b1;
                    st_next = otcv_pkg::ST_CMP;
                end
            end
            otcv_pkg::ST_CMP: begin
                if (sts.match) begin
                    cmd.scan_start = 1'b1;
                    st_next = otcv_pkg::ST_SCAN0;
                end else if (sts.cand_last) begin
                    rsp_next.verdict = otcv_pkg::VERDICT_FAKE;
                    rsp_next.coin_value = 4'd0;
                    st_next = otcv_pkg::ST_OUT;
                end else begin
                    cmd.cand_next = 1'b1;
                    st_next = otcv_pkg::ST_SEEDA;
                end
            end
            otcv_pkg::ST_SCAN0: begin
                // ram read latency
                st_next = otcv_pkg::ST_SCAN;
            end
            otcv_pkg::ST_SCAN: begin
                if (sts.scan_end) begin
                    st_next = otcv_pkg::ST_DONE;
                end else if (sts.scan_hit) begin
                    rsp_next.verdict = otcv_pkg::VERDICT_USED;
                    rsp_next.coin_value = 4'd0;
                    st_next = otcv_pkg::ST_OUT;
                end else begin
                    cmd.scan_step = 1'b1;
                    st_next = otcv_pkg::ST_SCAN0;
                end
            end
            otcv_pkg::ST_DONE: begin
                cmd.append = 1'b1;
                rsp_next.verdict = otcv_pkg::VERDICT_OK;
                rsp_next.coin_value = coin_dp;
                st_next = otcv_pkg::ST_OUT;
            end
            otcv_pkg::ST_OUT: begin
                if (m_ready) st_next = otcv_pkg::ST_IDLE;
            end
            default: st_next = otcv_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= otcv_pkg::ST_IDLE;
        end else begin
            st_reg <= st_next;
        end
        rsp_reg <= rsp_next;
    end

    assign s_ready = (st_reg == otcv_pkg::ST_IDLE);
    assign m_valid = (st_reg == otcv_pkg::ST_OUT);
    assign rsp = rsp_reg;
endmodule

// ----- rtl/one_time_code_verifier_top.sv -----
`timescale 1ns / 1ps
// search: each candidate starts half code a, starts half code b when a is done, then compares;
//   up to 350 candidates, after which a fake answer is given
// a match then scans the used list, a read wait state and a compare per entry, then appends
// flow: one request at a time; next request taken in the cycle after the result leaves
// reset: aresetn synchronous active low; clears fsm, list count, stored date,
//   serial back to 1234; used-list ram contents are not cleared
module one_time_code_verifier_top (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  otcv_pkg::req_t s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output otcv_pkg::rsp_t m_data,
    input  logic           cfg_we,
    input  logic [13:0]    cfg_wdata
);
    // device serial register; the user must write it only while idle, the block does not enforce it
    logic [13:0] serial_reg;
    otcv_pkg::cmd_t cmd;
    otcv_pkg::sts_t sts;
    logic [3:0] coin;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            serial_reg <= otcv_pkg::SERIAL_RESET;
        end else if (cfg_we) begin
            serial_reg <= cfg_wdata;
        end
    end

    // controller sequences candidates, datapath holds seeds, list and the half unit
    otcv_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .m_valid(m_valid), .m_ready(m_ready),
        .sts(sts), .coin_dp(coin), .cmd(cmd), .rsp(m_data)
    );

    otcv_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn),
        .req(s_data), .serial(serial_reg),
        .cmd(cmd), .sts(sts), .coin_out(coin)
    );
endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
module tb;

    typedef enum int { ROW_CODE, ROW_GEN, ROW_AGAIN } row_kind_t;

    typedef struct {
        row_kind_t      kind;
        logic [26:0]    code;
        logic [19:0]    date;
        int             coin;
        int             cnt;
        bit             typed;
        otcv_pkg::rsp_t want;
    } stim_row_t;

    localparam logic [19:0] DAY_A = 20'd240517;

    logic           aclk = 1'b0;
    logic           aresetn = 1'b0;
    logic           s_valid = 1'b0;
    logic           s_ready;
    otcv_pkg::req_t s_data = '0;
    logic           m_valid;
    logic           m_ready = 1'b0;
    otcv_pkg::rsp_t m_data;
    logic           cfg_we = 1'b0;
    logic [13:0]    cfg_wdata = '0;

    // predictor state
    logic [13:0]    serial_now = otcv_pkg::SERIAL_RESET;
    logic [19:0]    day_now = '0;
    logic [26:0]    day_used[$];
    otcv_pkg::rsp_t verdict_queue[$];
    logic [26:0]    last_code = '0;

    int  mismatch_count = 0;
    bit  quiet = 1'b0;

    one_time_code_verifier_top DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    always #5 aclk = ~aclk;

    // one lehmer step, folded into a four digit half
    function automatic logic [13:0] half_code(logic [31:0] seed);
        longint q, r, t;
        q = seed / 127773;
        r = seed % 127773;
        t = 16807 * r - 2836 * q;
        if (t <= 0) begin
            t += 64'h7FFF_FFFF;
        end
        return 14'(1000 + t % 9000);
    endfunction

    function automatic logic [26:0] otp_code(logic [19:0] date, int coin, int cnt);
        logic [31:0] seed_a, seed_b, cand;
        seed_a = {date, 12'b0} | 32'(cnt & 8'hFF);
        seed_b = {2'b0, serial_now, 16'b0} | (32'(cnt & 8'hFF) << 8) | 32'(coin & 8'hFF);
        cand = 32'(half_code(seed_a)) * 10000 + 32'(half_code(seed_b));
        return cand[26:0];
    endfunction

    // search order: coin outer, counter inner, first match wins
    function automatic otcv_pkg::rsp_t predict_verdict(logic [26:0] code, logic [19:0] date);
        otcv_pkg::rsp_t res;
        bit             hit;
        res.verdict    = otcv_pkg::VERDICT_FAKE;
        res.coin_value = '0;
        if (date != day_now) begin
            day_used.delete();
            day_now = date;
        end
        for (int coin = 1; coin < otcv_pkg::COIN_LIMIT; coin++) begin
            for (int cnt = 0; cnt < otcv_pkg::COUNTS_PER_DAY; cnt++) begin
                if (otp_code(date, coin, cnt) == code) begin
                    hit = 1'b0;
                    foreach (day_used[i]) begin
                        if (day_used[i] == code) hit = 1'b1;
                    end
                    if (hit) begin
                        res.verdict = otcv_pkg::VERDICT_USED;
                    end else begin
                        res.verdict    = otcv_pkg::VERDICT_OK;
                        res.coin_value = 4'(coin);
                        if (day_used.size() < otcv_pkg::USED_DEPTH) day_used.push_back(code);
                    end
                    return res;
                end
            end
        end
        return res;
    endfunction

    // drive one request; valid stays high into the next call unless a gap is drawn
    task automatic send_request(logic [26:0] code, logic [19:0] date, bit typed,
                                otcv_pkg::rsp_t want);
        otcv_pkg::rsp_t pred;
        int             gap;
        s_valid <= 1'b1;
        s_data  <= '{entered_code: code, date_code: date};
        do @(posedge aclk); while (!s_ready);
        pred = predict_verdict(code, date);
        verdict_queue.push_back(typed ? want : pred);
        last_code = code;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 8);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (verdict_queue.size() != 0) @(posedge aclk);
    endtask

    // only called with nothing in flight
    task automatic write_serial(logic [13:0] value);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        serial_now = value;
    endtask

    // result checker
    always @(posedge aclk) begin
        otcv_pkg::rsp_t exp_rsp;
        if (aresetn && m_valid && m_ready) begin
            if (verdict_queue.size() == 0) begin
                $display("%0t: unexpected result verdict=%0d coin=%0d",
                         $time, m_data.verdict, m_data.coin_value);
                mismatch_count++;
            end else begin
                exp_rsp = verdict_queue.pop_front();
                if (m_data.verdict !== exp_rsp.verdict) begin
                    $display("%0t: verdict expected %0d actual %0d",
                             $time, exp_rsp.verdict, m_data.verdict);
                    mismatch_count++;
                end
                if (m_data.coin_value !== exp_rsp.coin_value) begin
                    $display("%0t: coin_value expected %0d actual %0d",
                             $time, exp_rsp.coin_value, m_data.coin_value);
                    mismatch_count++;
                end
            end
        end
    end

    // receiver back-pressure in bursts
    initial begin
        int len;
        @(posedge aclk);
        forever begin
            len = $urandom_range(1, 8);
            if (quiet || $urandom_range(0, 2) != 0) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b0;
            end
            repeat (len) @(posedge aclk);
        end
    end

    initial begin
        #500ms;
        $display("Mismatches found");
        $finish;
    end

    initial begin
        stim_row_t      rows[$];
        stim_row_t      row;
        logic [26:0]    code;
        logic [19:0]    date;
        logic [26:0]    history[$];
        otcv_pkg::rsp_t fake_rsp;
        int             pick, coin, waited;

        fake_rsp.verdict    = otcv_pkg::VERDICT_FAKE;
        fake_rsp.coin_value = '0;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed rows
        rows.push_back('{ROW_CODE, 27'd0,        DAY_A, 0, 0, 1, fake_rsp});
        rows.push_back('{ROW_CODE, 27'd99999999, DAY_A, 0, 0, 0, fake_rsp});
        rows.push_back('{ROW_CODE, 27'h7FFFFFF,  DAY_A, 0, 0, 1, fake_rsp});
        rows.push_back('{ROW_GEN,  '0, DAY_A, 1, 0, 0, fake_rsp});
        rows.push_back('{ROW_AGAIN, '0, DAY_A, 0, 0, 0, fake_rsp});
        rows.push_back('{ROW_GEN,  '0, DAY_A, 14, 24, 0, fake_rsp});
        rows.push_back('{ROW_AGAIN, '0, DAY_A, 0, 0, 0, fake_rsp});
        rows.push_back('{ROW_GEN,  '0, DAY_A, 7, 12, 0, fake_rsp});
        rows.push_back('{ROW_GEN,  '0, 20'hFFFFF, 1, 0, 0, fake_rsp});
        rows.push_back('{ROW_AGAIN, '0, 20'hFFFFF, 0, 0, 0, fake_rsp});
        // back to the first day: list was cleared by the date change
        rows.push_back('{ROW_GEN,  '0, DAY_A, 1, 0, 0, fake_rsp});
        rows.push_back('{ROW_GEN,  '0, 20'd0, 2, 3, 0, fake_rsp});
        rows.push_back('{ROW_GEN,  '0, 20'd0, 1, 24, 0, fake_rsp});

        foreach (rows[i]) begin
            row = rows[i];
            case (row.kind)
                ROW_CODE:  code = row.code;
                ROW_GEN:   code = otp_code(row.date, row.coin, row.cnt);
                default:   code = last_code;
            endcase
            send_request(code, row.date, row.typed, row.want);
        end

        // random part over several serial settings, extremes included
        date = DAY_A;
        for (int n = 0; n < 290; n++) begin
            if (n == 0)   write_serial(14'd0);
            if (n == 70)  write_serial(14'd9999);
            if (n == 140) write_serial(14'($urandom_range(0, 9999)));
            if (n == 200) drain_results();
            if (n == 230) write_serial(otcv_pkg::SERIAL_RESET);
            if (n == 260) quiet = 1'b1;
            if (n == 0 || n == 70 || n == 140 || n == 230) history.delete();

            if ($urandom_range(0, 99) < 4) begin
                date = ($urandom_range(0, 1)) ? 20'($urandom) : 20'($urandom_range(0, 999999));
                history.delete();
            end
            pick = $urandom_range(0, 99);
            if (pick < 68) begin
                code = otp_code(date, 1, $urandom_range(0, otcv_pkg::COUNTS_PER_DAY - 1));
            end else if (pick < 80) begin
                code = otp_code(date, $urandom_range(2, 3),
                                $urandom_range(0, otcv_pkg::COUNTS_PER_DAY - 1));
            end else if (pick < 84) begin
                coin = $urandom_range(1, otcv_pkg::COIN_LIMIT - 1);
                code = otp_code(date, coin, $urandom_range(0, otcv_pkg::COUNTS_PER_DAY - 1));
            end else if (pick < 94 && history.size() != 0) begin
                code = history[$urandom_range(0, history.size() - 1)];
            end else begin
                // noise: random bits or values up to 99999999, all of them fake or rare hits
                code = ($urandom_range(0, 1)) ? 27'($urandom) : 27'($urandom_range(0, 99999999));
            end
            history.push_back(code);
            send_request(code, date, 1'b0, fake_rsp);
        end

        s_valid <= 1'b0;
        waited = 0;
        while (verdict_queue.size() != 0 && waited < 2000000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (200) @(posedge aclk);
        if (verdict_queue.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, verdict_queue.size());
            mismatch_count++;
        end

        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/otcv_pkg.sv
rtl/otcv_ram.sv
rtl/otcv_half.sv
rtl/otcv_datapath.sv
rtl/otcv_ctrl.sv
rtl/one_time_code_verifier_top.sv
verif/tb.sv
